[hw/rtl/ode_pkg.sv]
// ode_pkg: shared types and codes for the dr/bdr election block
// depends on nothing
package ode_pkg;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_UP     = 2'd1;
    localparam logic [1:0] MODE_BACKUP = 2'd2;
    localparam logic [1:0] MODE_NBRCHG = 2'd3;

    localparam logic [2:0] ST_DOWN    = 3'd0;
    localparam logic [2:0] ST_WAITING = 3'd1;
    localparam logic [2:0] ST_P2P     = 3'd2;
    localparam logic [2:0] ST_DROTHER = 3'd3;
    localparam logic [2:0] ST_BACKUP  = 3'd4;
    localparam logic [2:0] ST_DR      = 3'd5;

    localparam logic [2:0] NET_P2P  = 3'd2;
    localparam logic [2:0] NET_VIRT = 3'd4;

    localparam logic [1:0] CFG_ADDR = 2'd0;
    localparam logic [1:0] CFG_RID  = 2'd1;
    localparam logic [1:0] CFG_PRI  = 2'd2;
    localparam logic [1:0] CFG_NET  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot;
        logic        entry_valid;
        logic [31:0] neighbor_address;
        logic [31:0] neighbor_router_id;
        logic [7:0]  neighbor_priority;
        logic [31:0] neighbor_declared_dr;
        logic [31:0] neighbor_declared_bdr;
        logic        neighbor_two_way;
    } t_in;

    typedef struct packed {
        logic [2:0]  iface_state;
        logic [31:0] dr_address;
        logic [31:0] bdr_address;
        logic        event_accepted;
        logic        adjacency_recheck;
        logic        election_error;
    } t_out;

    // controller -> datapath commands
    typedef struct packed {
        logic round_init;   // start round: reset scan indexes/winners
        logic scan_bdr;     // evaluate one bdr candidate
        logic scan_dr;      // evaluate one dr candidate
        logic round_commit; // latch round winners into dr/bdr
        logic restore;      // put back pre-election dr/bdr
        logic elect_begin;  // snapshot dr/bdr, clear late flag
        logic finish;       // update late flag for the next round
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic scan_last;    // current candidate is the last one
        logic bdr_found;
        logic again;        // self newly became dr or bdr
    } t_sts;

endpackage

[hw/rtl/ode_datapath.sv]
// ode_datapath: neighbor table memory, dr/bdr registers and the candidate scan unit
// depends on ode_pkg
module ode_datapath
    import ode_pkg::*;
#(
    parameter int NEIGHBORS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  t_in         i_item,
    input  logic [31:0] i_own_address,
    input  logic [31:0] i_own_router_id,
    input  logic [7:0]  i_own_priority,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [31:0] o_dr,
    output logic [31:0] o_bdr,
    output logic        o_changed
);
    localparam int IW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int CW = $clog2(NEIGHBORS + 2);

    // memory rows: address, id, priority, declared dr, declared bdr
    logic [135:0] r_mem [NEIGHBORS];
    logic [NEIGHBORS-1:0] r_ok;          // valid and two-way
    logic [135:0] r_rd;

    // candidate index: 0 = self first, 1..N = slots, N+1 = self last
    logic [CW-1:0] r_idx;
    logic          r_late;
    logic [31:0] r_dr, r_bdr, r_first_dr, r_first_bdr;
    logic [31:0] r_first_dr_r, r_bdr_prev;
    logic        r_bv, r_dv;
    logic [31:0] r_b_ip, r_b_id, r_b_bd, r_d_ip, r_d_id;
    logic [7:0]  r_b_pri, r_d_pri;
    logic        r_rd_ok;

    logic [31:0] c_ip, c_id, c_dr, c_bdr;
    logic [7:0]  c_pri;
    logic        c_ok, c_self, b_beats, d_beats;
    logic [CW-1:0] n_idx;
    logic [IW-1:0] slot_idx;

    assign slot_idx = (n_idx >= CW'(1) && n_idx <= CW'(NEIGHBORS)) ?
                      IW'(n_idx - CW'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr && (32'(i_item.slot) < NEIGHBORS))
            r_mem[IW'(i_item.slot)] <= {i_item.neighbor_address, i_item.neighbor_router_id,
                i_item.neighbor_priority, i_item.neighbor_declared_dr,
                i_item.neighbor_declared_bdr};
        r_rd <= r_mem[slot_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= '0;
        end else if (i_wr && (32'(i_item.slot) < NEIGHBORS)) begin
            r_ok[IW'(i_item.slot)] <= i_item.entry_valid & i_item.neighbor_two_way;
        end
    end

    always_comb begin
        c_self = (r_idx == '0) || (r_idx == CW'(NEIGHBORS + 1));
        if (c_self) begin
            c_ip = i_own_address; c_id = i_own_router_id; c_pri = i_own_priority;
            c_dr = r_dr; c_bdr = r_bdr;
            // a late self only joins the dr pass
            c_ok = (i_own_priority != 8'd0) &&
                   ((r_idx == '0) ? !r_late : (r_late && i_cmd.scan_dr));
        end else begin
            {c_ip, c_id, c_pri, c_dr, c_bdr} = r_rd;
            c_ok = r_rd_ok && (c_pri != 8'd0);
        end
        b_beats = (c_pri > r_b_pri) || (c_pri == r_b_pri && c_id > r_b_id);
        d_beats = (c_pri > r_d_pri) || (c_pri == r_d_pri && c_id > r_d_id);
        n_idx = i_cmd.round_init ? '0 : ((i_cmd.scan_bdr || i_cmd.scan_dr) ?
                r_idx + CW'(1) : r_idx);
    end

    assign o_sts.scan_last = (r_idx == CW'(NEIGHBORS + 1));
    assign o_sts.bdr_found = r_bv;
    assign o_sts.again = ((i_own_address == r_dr) && (i_own_address != r_first_dr_r))
                         || ((i_own_address == r_bdr) && (i_own_address != r_bdr_prev));

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_rd_ok <= (n_idx >= CW'(1) && n_idx <= CW'(NEIGHBORS)) ? r_ok[slot_idx] : 1'b0;
        if (i_cmd.elect_begin) begin
            r_first_dr <= r_dr; r_first_bdr <= r_bdr; r_late <= 1'b0;
        end
        if (i_cmd.round_init) begin
            r_bv <= 1'b0; r_dv <= 1'b0;
        end
        if (i_cmd.scan_bdr && c_ok && c_dr != c_ip) begin
            if (!r_bv || (r_b_bd == r_b_ip ? (c_bdr == c_ip && b_beats)
                                           : (c_bdr == c_ip || b_beats))) begin
                r_bv <= 1'b1; r_b_ip <= c_ip; r_b_id <= c_id;
                r_b_pri <= c_pri; r_b_bd <= c_bdr;
            end
        end
        if (i_cmd.scan_dr && c_ok && c_dr == c_ip && (!r_dv || d_beats)) begin
            r_dv <= 1'b1; r_d_ip <= c_ip; r_d_id <= c_id; r_d_pri <= c_pri;
        end
        if (i_cmd.finish) begin
            // late flag for the next round follows who newly won
            r_late <= (i_own_address == r_dr) && (i_own_address != r_first_dr_r);
        end
        if (!i_rst_n) begin
            r_dr <= '0; r_bdr <= '0;
        end else if (i_cmd.restore) begin
            r_dr <= r_first_dr; r_bdr <= r_first_bdr;
        end else if (i_cmd.round_commit) begin
            r_first_dr_r <= r_dr; r_bdr_prev <= r_bdr;
            r_dr  <= r_dv ? r_d_ip : r_b_ip;
            r_bdr <= r_b_ip;
        end
    end

    assign o_dr = r_dr;
    assign o_bdr = r_bdr;
    assign o_changed = (r_dr != r_first_dr) || (r_bdr != r_first_bdr);
endmodule

[hw/rtl/ode_ctrl.sv]
// ode_ctrl: controller state machine sequencing election rounds
// depends on ode_pkg
module ode_ctrl
    import ode_pkg::*;
#(
    parameter int MAX_PASSES = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_go,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_done,
    output logic o_err
);
    localparam int PW = $clog2(MAX_PASSES + 1);
    localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_BDR = 4'd2, S_MID = 4'd3,
                           S_DR = 4'd4, S_CHK = 4'd5, S_NEXT = 4'd6, S_CMT = 4'd7,
                           S_ERR = 4'd8;
    logic [3:0]    r_st, n_st;
    logic [PW-1:0] r_pass, n_pass;

    always_comb begin
        o_cmd = '0; o_done = 1'b0; o_err = 1'b0;
        n_st = r_st; n_pass = r_pass;
        case (r_st)
            S_IDLE: if (i_go) begin
                o_cmd.elect_begin = 1'b1; o_cmd.round_init = 1'b1;
                n_pass = '0; n_st = S_BDR;
            end
            S_INIT: begin
                o_cmd.round_init = 1'b1; n_st = S_BDR;
            end
            S_BDR: begin
                o_cmd.scan_bdr = 1'b1;
                if (i_sts.scan_last) n_st = S_MID;
            end
            S_MID: begin
                if (!i_sts.bdr_found) begin
                    o_cmd.restore = 1'b1; n_st = S_ERR;
                end else begin
                    o_cmd.round_init = 1'b1; n_st = S_DR;
                end
            end
            S_DR: begin
                o_cmd.scan_dr = 1'b1;
                if (i_sts.scan_last) n_st = S_CMT;
            end
            S_CMT: begin
                o_cmd.round_commit = 1'b1; n_st = S_CHK;
            end
            S_CHK: begin
                o_cmd.finish = 1'b1;
                n_pass = r_pass + PW'(1);
                if (i_sts.again && (r_pass + PW'(1) < PW'(MAX_PASSES))) n_st = S_INIT;
                else n_st = S_NEXT;
            end
            S_NEXT: begin
                o_done = 1'b1; n_st = S_IDLE;
            end
            S_ERR: begin
                o_done = 1'b1; o_err = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_pass <= '0;
        end else begin
            r_st <= n_st; r_pass <= n_pass;
        end
    end

    assign o_busy = (r_st != S_IDLE);
endmodule

[hw/rtl/ospf_dr_bdr_election_core.sv]
// ospf_dr_bdr_election_core: interface state machine with dr/bdr election
// depends on ode_pkg, ode_ctrl, ode_datapath
//
// channel   | direction | handshake
// ----------+-----------+--------------------------------------
// command   | in        | transfer when i_start && !o_busy
// result    | out       | one cycle with o_valid, no stall
// config    | in        | transfer when i_cfg_we
//
// table writes and non-election events answer in the cycle after the transfer
// an election round scans NEIGHBORS+2 candidate positions twice through the one
// table read port; later rounds start with S_INIT and the result comes in S_NEXT
// no bdr found answers through S_MID and S_ERR after the bdr scan; the receiver cannot stall
// reset clears state, dr/bdr and table valid bits; no clearing pass
module ospf_dr_bdr_election_core
    import ode_pkg::*;
#(
    parameter int NEIGHBORS  = 16,
    parameter int MAX_PASSES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in         i_item,
    output logic        o_valid,
    output t_out        o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_own_addr, r_own_rid;
    logic [7:0]  r_own_pri;
    logic [2:0]  r_net, r_state;
    logic        r_elect;
    t_cmd cmd;
    t_sts sts;
    logic c_busy, c_done, c_err, changed, accept, wr, go, evt_ok;
    logic [31:0] dr, bdr;

    assign accept = i_start && !o_busy;
    assign wr = accept && (i_item.mode == MODE_WRITE);
    assign evt_ok = (i_item.mode == MODE_BACKUP) ? (r_state == ST_WAITING) :
                    (i_item.mode == MODE_NBRCHG) ? (r_state == ST_DR ||
                     r_state == ST_BACKUP || r_state == ST_DROTHER) : 1'b0;
    assign go = accept && evt_ok;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= '0; r_own_rid <= '0; r_own_pri <= 8'd1; r_net <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ADDR: r_own_addr <= i_cfg_data;
                CFG_RID:  r_own_rid  <= i_cfg_data;
                CFG_PRI:  r_own_pri  <= i_cfg_data[7:0];
                CFG_NET:  r_net      <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    ode_ctrl #(.MAX_PASSES(MAX_PASSES)) u_ctrl (
        .i_clk, .i_rst_n, .i_go(go), .i_sts(sts), .o_cmd(cmd),
        .o_busy(c_busy), .o_done(c_done), .o_err(c_err));

    ode_datapath #(.NEIGHBORS(NEIGHBORS)) u_dp (
        .i_clk, .i_rst_n, .i_wr(wr), .i_item, .i_own_address(r_own_addr),
        .i_own_router_id(r_own_rid), .i_own_priority(r_own_pri),
        .i_cmd(cmd), .o_sts(sts), .o_dr(dr), .o_bdr(bdr), .o_changed(changed));

    logic r_pend;  // simple event answered next cycle
    logic r_acc;
    assign o_busy = c_busy || r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DOWN; r_pend <= 1'b0; r_acc <= 1'b0; r_elect <= 1'b0;
        end else begin
            r_pend <= accept && !evt_ok;
            if (accept) begin
                r_elect <= evt_ok;
                r_acc <= (i_item.mode == MODE_WRITE) ||
                         (i_item.mode == MODE_UP && r_state == ST_DOWN);
                if (i_item.mode == MODE_UP && r_state == ST_DOWN) begin
                    if (r_net >= NET_P2P && r_net <= NET_VIRT) r_state <= ST_P2P;
                    else if (r_own_pri != 8'd0) r_state <= ST_WAITING;
                    else r_state <= ST_DROTHER;
                end
            end
            if (c_done && !c_err) begin
                if (r_own_addr == dr) r_state <= ST_DR;
                else if (r_own_addr == bdr) r_state <= ST_BACKUP;
                else r_state <= ST_DROTHER;
            end
        end
    end

    // result: simple events next cycle, elections once the controller finishes
    always_comb begin
        o_valid = r_pend || c_done;
        o_result.iface_state = r_state;
        o_result.dr_address = dr;
        o_result.bdr_address = bdr;
        o_result.event_accepted = c_done ? 1'b1 : r_acc;
        o_result.adjacency_recheck = 1'b0;
        o_result.election_error = c_done && c_err;
        if (c_done && !c_err) begin
            o_result.adjacency_recheck = changed;
            o_result.iface_state = (r_own_addr == dr) ? ST_DR :
                                   (r_own_addr == bdr) ? ST_BACKUP : ST_DROTHER;
        end
        if (c_done && c_err) begin
            o_result.dr_address = dr;
        end
        if (!r_elect && !r_pend) o_result.event_accepted = r_acc;
    end
endmodule

[bench/tb_ospf_dr_bdr_election_core.sv]
`timescale 1ns / 1ps
// tb_ospf_dr_bdr_election_core: self-checking bench for the dr/bdr election core
// depends on ode_pkg and ospf_dr_bdr_election_core; predicts every result and compares
module tb_ospf_dr_bdr_election_core;
    import ode_pkg::*;

    localparam int NBR        = 16;
    localparam int PASSES     = 4;
    localparam int RAND_ITEMS = 1900;
    localparam int LIMIT      = 2000000;
    localparam int DRAIN      = 600;
    localparam int IN_W       = $bits(t_in);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in         i_item;
    logic        o_valid;
    t_out        o_result;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    ospf_dr_bdr_election_core #(.NEIGHBORS(NBR), .MAX_PASSES(PASSES)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // candidate record for one election scan
    typedef struct {
        logic [31:0] addr;
        logic [31:0] rid;
        logic [31:0] ddr;
        logic [31:0] dbdr;
        logic [7:0]  pri;
    } t_cand;

    // predicted interface copy
    logic [31:0] my_addr, my_rid;
    logic [7:0]  my_pri;
    logic [2:0]  my_net;
    logic [2:0]  if_state;
    logic [31:0] cur_dr, cur_bdr;
    t_cand       nbr_tab [NBR];
    logic        nbr_valid [NBR];
    logic        nbr_twoway [NBR];

    // expected results in transfer order
    t_out        exp_q [4];
    int          q_wr;
    int          q_rd;
    int          err_cnt;
    int          cycle_cnt;

    function automatic bit outranks(t_cand a, t_cand b);
        return a.pri > b.pri || (a.pri == b.pri && a.rid > b.rid);
    endfunction

    // one round: bdr scan then dr scan; returns 0 if no bdr
    function automatic bit elect_round(bit self_late, output logic [31:0] ndr,
                                       output logic [31:0] nbdr);
        t_cand pool [NBR+1];
        t_cand me;
        int    n, bi, di;
        bit    decl;
        n = 0;
        bi = -1;
        di = -1;
        me.addr = my_addr;
        me.rid  = my_rid;
        me.ddr  = cur_dr;
        me.dbdr = cur_bdr;
        me.pri  = my_pri;
        if (!self_late && my_pri != 0) begin
            pool[n] = me;
            n++;
        end
        for (int i = 0; i < NBR; i++)
            if (nbr_valid[i] && nbr_twoway[i] && nbr_tab[i].pri != 0) begin
                pool[n] = nbr_tab[i];
                n++;
            end
        for (int i = 0; i < n; i++) begin
            decl = (pool[i].dbdr == pool[i].addr);
            if (pool[i].ddr == pool[i].addr) continue;
            if (bi < 0) bi = i;
            else if (pool[bi].dbdr == pool[bi].addr) begin
                if (decl && outranks(pool[i], pool[bi])) bi = i;
            end else if (decl || outranks(pool[i], pool[bi])) bi = i;
        end
        ndr = '0;
        nbdr = '0;
        if (bi < 0) return 1'b0;
        if (self_late && my_pri != 0) begin
            pool[n] = me;
            n++;
        end
        for (int i = 0; i < n; i++) begin
            if (pool[i].ddr != pool[i].addr) continue;
            if (di < 0 || outranks(pool[i], pool[di])) di = i;
        end
        if (di < 0) di = bi;
        ndr = pool[di].addr;
        nbdr = pool[bi].addr;
        return 1'b1;
    endfunction

    // full election with pass limit, updates predicted state
    function automatic void run_election(output logic err, output logic recheck);
        logic [31:0] dr0, bdr0, ndr, nbdr, odr, obdr;
        bit          late;
        dr0 = cur_dr;
        bdr0 = cur_bdr;
        late = 0;
        err = 0;
        recheck = 0;
        for (int p = 0; p < PASSES; p++) begin
            if (!elect_round(late, ndr, nbdr)) begin
                cur_dr = dr0;
                cur_bdr = bdr0;
                err = 1;
                return;
            end
            odr = cur_dr;
            obdr = cur_bdr;
            cur_dr = ndr;
            cur_bdr = nbdr;
            if (my_addr == ndr && my_addr != odr) late = 1;
            else if (my_addr == nbdr && my_addr != obdr) late = 0;
            else break;
        end
        recheck = (cur_dr != dr0 || cur_bdr != bdr0);
        if (my_addr == cur_dr) if_state = ST_DR;
        else if (my_addr == cur_bdr) if_state = ST_BACKUP;
        else if_state = ST_DROTHER;
    endfunction

    // interface event prediction for one accepted command
    function automatic t_out predict_event(t_in it);
        t_out r;
        logic acc, err, rc;
        acc = 0;
        err = 0;
        rc = 0;
        case (it.mode)
            MODE_WRITE: begin
                acc = 1;
                nbr_valid[it.slot]  = it.entry_valid;
                nbr_twoway[it.slot] = it.entry_valid & it.neighbor_two_way;
                nbr_tab[it.slot].addr = it.neighbor_address;
                nbr_tab[it.slot].rid  = it.neighbor_router_id;
                nbr_tab[it.slot].pri  = it.neighbor_priority;
                nbr_tab[it.slot].ddr  = it.neighbor_declared_dr;
                nbr_tab[it.slot].dbdr = it.neighbor_declared_bdr;
            end
            MODE_UP: begin
                if (if_state == ST_DOWN) begin
                    acc = 1;
                    if (my_net >= NET_P2P && my_net <= NET_VIRT) if_state = ST_P2P;
                    else if (my_pri != 0) if_state = ST_WAITING;
                    else if_state = ST_DROTHER;
                end
            end
            MODE_BACKUP: begin
                if (if_state == ST_WAITING) begin
                    acc = 1;
                    run_election(err, rc);
                end
            end
            default: begin
                if (if_state == ST_DR || if_state == ST_BACKUP || if_state == ST_DROTHER) begin
                    acc = 1;
                    run_election(err, rc);
                end
            end
        endcase
        r.iface_state = if_state;
        r.dr_address = cur_dr;
        r.bdr_address = cur_bdr;
        r.event_accepted = acc;
        r.adjacency_recheck = rc;
        r.election_error = err;
        return r;
    endfunction

    // config write, only called while idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        case (idx)
            CFG_ADDR: my_addr = val;
            CFG_RID:  my_rid = val;
            CFG_PRI:  my_pri = val[7:0];
            default:  my_net = val[2:0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // issue one command transfer after a random gap
    task automatic send_cmd(t_in it, bit has_fixed, t_out fixed);
        t_out exp_r;
        int   gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        repeat (gap) @(negedge i_clk);
        i_item = it;
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        // transfer happens at this edge
        exp_r = predict_event(it);
        if (has_fixed && exp_r != fixed) begin
            $display("%0t table row mismatch: expected %h predicted %h", $time, fixed, exp_r);
            err_cnt++;
        end
        exp_q[q_wr % 4] = exp_r;
        q_wr++;
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    // wait until idle then extra cycles for a trailing election
    task automatic settle();
        while (q_wr != q_rd) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (q_wr == q_rd) begin
                $display("%0t unexpected result: expected none actual %h", $time, o_result);
                err_cnt++;
            end else begin
                want = exp_q[q_rd % 4];
                q_rd++;
                if (o_result.iface_state !== want.iface_state ||
                    o_result.dr_address !== want.dr_address ||
                    o_result.bdr_address !== want.bdr_address ||
                    o_result.event_accepted !== want.event_accepted ||
                    o_result.adjacency_recheck !== want.adjacency_recheck ||
                    o_result.election_error !== want.election_error) begin
                    $display("%0t result mismatch: expected %h actual %h",
                             $time, want, o_result);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_in mk(logic [1:0] m, logic [3:0] s, logic v, logic [31:0] a,
                               logic [31:0] id, logic [7:0] p, logic [31:0] d,
                               logic [31:0] b, logic tw);
        t_in it;
        it.mode = m;
        it.slot = s;
        it.entry_valid = v;
        it.neighbor_address = a;
        it.neighbor_router_id = id;
        it.neighbor_priority = p;
        it.neighbor_declared_dr = d;
        it.neighbor_declared_bdr = b;
        it.neighbor_two_way = tw;
        return it;
    endfunction

    function automatic t_out res(logic [2:0] s, logic [31:0] d, logic [31:0] b,
                                 logic a, logic rc, logic e);
        t_out r;
        r.iface_state = s;
        r.dr_address = d;
        r.bdr_address = b;
        r.event_accepted = a;
        r.adjacency_recheck = rc;
        r.election_error = e;
        return r;
    endfunction

    // small address pool so declarations and ties hit often
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return 32'h0a000001;
            1: return 32'hffffffff;
            2: return 32'h00000000;
            3: return my_addr;
            default: return {28'h0a00000, 4'($urandom_range(0, 15))};
        endcase
    endfunction

    function automatic t_in rand_cmd();
        t_in it;
        it = t_in'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        it.mode = 2'($urandom_range(0, 9) < 6 ? MODE_WRITE : $urandom_range(1, 3));
        if ($urandom_range(0, 9) != 0) begin
            it.neighbor_address = pick_addr();
            it.neighbor_router_id = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3);
            it.neighbor_priority = 8'($urandom_range(0, 3) == 0 ? $urandom
                                                                : $urandom_range(0, 2));
            it.neighbor_declared_dr = $urandom_range(0, 1) ? it.neighbor_address : pick_addr();
            it.neighbor_declared_bdr = $urandom_range(0, 1) ? it.neighbor_address : pick_addr();
            it.entry_valid = $urandom_range(0, 4) != 0;
            it.neighbor_two_way = $urandom_range(0, 4) != 0;
        end
        return it;
    endfunction

    typedef struct {
        t_in  cmd;
        bit   fixed;
        t_out want;
    } t_row;

    t_row rows [16];
    int   n_rows;
    t_out none;

    function automatic void add_row(t_in c, bit f, t_out w);
        rows[n_rows] = '{c, f, w};
        n_rows++;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_ADDR;
        i_cfg_data = '0;
        err_cnt = 0;
        cycle_cnt = 0;
        q_wr = 0;
        q_rd = 0;
        n_rows = 0;
        none = '0;
        my_addr = '0;
        my_rid = '0;
        my_pri = 8'd1;
        my_net = '0;
        if_state = ST_DOWN;
        cur_dr = '0;
        cur_bdr = '0;
        for (int i = 0; i < NBR; i++) begin
            nbr_valid[i] = 0;
            nbr_twoway[i] = 0;
            nbr_tab[i] = '{default: '0};
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset values, events in wrong state, extremes
        add_row(mk(MODE_BACKUP, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(ST_DOWN, 0, 0, 0, 0, 0));
        add_row(mk(MODE_NBRCHG, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(ST_DOWN, 0, 0, 0, 0, 0));
        add_row(mk(MODE_UP, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(ST_WAITING, 0, 0, 1, 0, 0));
        add_row(mk(MODE_UP, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                res(ST_WAITING, 0, 0, 0, 0, 0));
        add_row(mk(MODE_WRITE, 4'hf, 1, '1, '1, 8'hff, '1, '1, 1), 1,
                res(ST_WAITING, 0, 0, 1, 0, 0));
        add_row(mk(MODE_WRITE, 0, 1, 32'h0a000002, 5, 8'd1, 0, 0, 1), 0, none);
        add_row(mk(MODE_WRITE, 1, 1, 32'h0a000003, 5, 8'd1, 0, 32'h0a000003, 0),
                0, none);
        add_row(mk(MODE_BACKUP, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(MODE_NBRCHG, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(MODE_WRITE, 4'hf, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(MODE_WRITE, 2, 1, 32'h0a000009, 9, 8'd7, 32'h0a000009,
                32'h0a000009, 1), 0, none);
        add_row(mk(MODE_NBRCHG, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        for (int i = 0; i < n_rows; i++) send_cmd(rows[i].cmd, rows[i].fixed, rows[i].want);
        settle();

        // point-to-point style network settings; no command is sent before the phases rewrite them
        write_reg(CFG_NET, 32'(NET_VIRT));
        write_reg(CFG_PRI, 32'd0);
        write_reg(CFG_ADDR, 32'h0a000001);
        write_reg(CFG_RID, 32'hffffffff);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            // new settings each phase, extremes in the first ones
            write_reg(CFG_ADDR, ph == 0 ? 32'hffffffff : pick_addr());
            write_reg(CFG_RID, ph == 1 ? 32'h0 : (ph == 2 ? 32'hffffffff : $urandom_range(0, 3)));
            write_reg(CFG_PRI, ph == 3 ? 32'hff : (ph == 4 ? 32'd0 : $urandom_range(0, 2)));
            write_reg(CFG_NET, ph < 5 ? 32'($urandom_range(0, 1)) : 32'($urandom_range(0, 7)));
            for (int k = 0; k < RAND_ITEMS / 8; k++)
                send_cmd(rand_cmd(), 0, none);
        end
        settle();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
